// ----- rtl/gdd_pkg.sv -----
// Shared types and constants for the Gregorian date difference unit.
package gdd_pkg;

   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int YEAR_W     = 14;
   localparam int DAY_NUM_W  = 23;
   localparam int NUM_STAGES = 4;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;
   localparam logic [DAY_W-1:0]   LEAP_FEB_LEN = 5'd29;

   localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

   // x / 25 == (x * 5243) >> 17 for every x below 4096
   localparam logic [12:0] DIV25_MUL   = 13'd5243;
   localparam int          DIV25_SHIFT = 17;
   localparam logic [4:0]  QUADS_PER_CENTURY = 5'd25;

   localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   localparam logic [8:0] DAYS_BEFORE [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
   };

   typedef struct packed {
      logic [DAY_W-1:0]   start_day;
      logic [MONTH_W-1:0] start_month;
      logic [YEAR_W-1:0]  start_year;
      logic [DAY_W-1:0]   end_day;
      logic [MONTH_W-1:0] end_month;
      logic [YEAR_W-1:0]  end_year;
   } req_payload_type;

   typedef struct packed {
      logic signed [DAY_NUM_W-1:0] day_count;
      logic                        status;
   } rsp_payload_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctl_type;

endpackage

// ----- rtl/gdd_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transaction.
interface gdd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/gdd_day_number.sv -----
// Four-stage pipeline: validity check and day number of one date.
module gdd_day_number #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                                clock,
   input  gdd_pkg::stage_ctl_type              stage_ctl,
   input  logic [gdd_pkg::DAY_W-1:0]           day,
   input  logic [gdd_pkg::MONTH_W-1:0]         month,
   input  logic [gdd_pkg::YEAR_W-1:0]          year,
   output logic [gdd_pkg::DAY_NUM_W-1:0]       day_num,
   output logic                                date_ok
);

   localparam int SH = gdd_pkg::DIV25_SHIFT;

   // stage 1
   logic [gdd_pkg::DAY_W-1:0]     d1_ff;
   logic [gdd_pkg::MONTH_W-1:0]   m1_ff;
   logic [gdd_pkg::YEAR_W-1:0]    y1_ff, p1_ff;
   logic [gdd_pkg::DAY_NUM_W-1:0] p365_ff, p365_in;
   logic [24:0] mp4_ff, mp4_in, my4_ff, my4_in;
   logic [22:0] mp16_ff, mp16_in, my16_ff, my16_in;
   logic        ok1_ff, ok1_in;
   logic [gdd_pkg::YEAR_W-1:0] p_in;

   // stage 2
   logic [gdd_pkg::DAY_W-1:0]     d2_ff;
   logic [gdd_pkg::MONTH_W-1:0]   m2_ff;
   logic [gdd_pkg::DAY_NUM_W-1:0] a2_ff, a2_in;
   logic [5:0]  q400_ff;
   logic        leap2_ff, leap_in, ok2_ff, ok2_in;
   logic [7:0]  qy4;
   logic [5:0]  qy16;
   logic [11:0] ry4;
   logic [9:0]  ry16;
   logic [gdd_pkg::DAY_W-1:0] mlen;

   // stage 3
   logic [gdd_pkg::DAY_NUM_W-1:0] a3_ff, b3_ff, b3_in;
   logic        ok3_ff;

   // stage 4
   logic [gdd_pkg::DAY_NUM_W-1:0] n4_ff;
   logic        ok4_ff;

   always_comb begin
      p_in    = year - gdd_pkg::YEAR_W'(1);
      p365_in = gdd_pkg::DAY_NUM_W'(p_in) * gdd_pkg::DAY_NUM_W'(gdd_pkg::DAYS_PER_YEAR);
      mp4_in  = 25'(p_in[13:2]) * 25'(gdd_pkg::DIV25_MUL);
      my4_in  = 25'(year[13:2]) * 25'(gdd_pkg::DIV25_MUL);
      mp16_in = 23'(p_in[13:4]) * 23'(gdd_pkg::DIV25_MUL);
      my16_in = 23'(year[13:4]) * 23'(gdd_pkg::DIV25_MUL);
      ok1_in  = (year != '0) && (year <= gdd_pkg::YEAR_W'(MAX_YEAR))
                && (month inside {[gdd_pkg::JANUARY:gdd_pkg::DECEMBER]})
                && (day != '0);
   end

   always_ff @(posedge clock) begin
      if (stage_ctl.load[0]) begin
         d1_ff   <= day;
         m1_ff   <= month;
         y1_ff   <= year;
         p1_ff   <= p_in;
         p365_ff <= p365_in;
         mp4_ff  <= mp4_in;
         my4_ff  <= my4_in;
         mp16_ff <= mp16_in;
         my16_ff <= my16_in;
         ok1_ff  <= ok1_in;
      end
   end

   // leap: y%4==0 and (y%400==0 or y%100!=0), via (y>>2)%25 and (y>>4)%25
   always_comb begin
      qy4   = my4_ff[SH+7:SH];
      qy16  = my16_ff[SH+5:SH];
      ry4   = y1_ff[13:2] - 12'(qy4) * 12'(gdd_pkg::QUADS_PER_CENTURY);
      ry16  = y1_ff[13:4] - 10'(qy16) * 10'(gdd_pkg::QUADS_PER_CENTURY);
      leap_in = (y1_ff[1:0] == 2'b00)
                && (((y1_ff[3:2] == 2'b00) && (ry16 == '0)) || (ry4 != '0));
      mlen = gdd_pkg::MONTH_LEN[m1_ff];
      if (m1_ff == gdd_pkg::FEBRUARY && leap_in) begin
         mlen = gdd_pkg::LEAP_FEB_LEN;
      end
      ok2_in = ok1_ff && (d1_ff <= mlen);
      a2_in  = p365_ff + gdd_pkg::DAY_NUM_W'(p1_ff[13:2])
               - gdd_pkg::DAY_NUM_W'(mp4_ff[SH+7:SH]);
   end

   always_ff @(posedge clock) begin
      if (stage_ctl.load[1]) begin
         d2_ff    <= d1_ff;
         m2_ff    <= m1_ff;
         a2_ff    <= a2_in;
         q400_ff  <= mp16_ff[SH+5:SH];
         leap2_ff <= leap_in;
         ok2_ff   <= ok2_in;
      end
   end

   always_comb begin
      b3_in = gdd_pkg::DAY_NUM_W'(q400_ff)
              + gdd_pkg::DAY_NUM_W'(gdd_pkg::DAYS_BEFORE[m2_ff])
              + gdd_pkg::DAY_NUM_W'(d2_ff)
              + gdd_pkg::DAY_NUM_W'((m2_ff > gdd_pkg::FEBRUARY) && leap2_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_ctl.load[2]) begin
         a3_ff  <= a2_ff;
         b3_ff  <= b3_in;
         ok3_ff <= ok2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ctl.load[3]) begin
         n4_ff  <= a3_ff + b3_ff;
         ok4_ff <= ok3_ff;
      end
   end

   assign day_num = n4_ff;
   assign date_ok = ok4_ff;

endmodule

// ----- rtl/gregorian_date_difference_unit.sv -----
// An accepted req transaction passes through 4 stages + output reg before rsp valid.
// Throughput: one transaction per cycle; each stage advances when its successor frees up,
// so bubbles are squeezed out and a stalled rsp holds the pipe without loss.
// Reset (synchronous, active high) clears all stage valid bits; payload regs are not reset.
// Stage depth is set by the 12x13 reciprocal multipliers and the 23-bit adders.
module gregorian_date_difference_unit #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input logic          clock,
   input logic          reset,
   gdd_stream_if.sink   req_chan,
   gdd_stream_if.source rsp_chan
);

   localparam int NS = gdd_pkg::NUM_STAGES;

   logic [NS:0]   v_ff;
   logic [NS:0]   load;
   logic [NS-1:0] gt_ff;
   gdd_pkg::stage_ctl_type   stage_ctl;
   gdd_pkg::req_payload_type req;
   gdd_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [gdd_pkg::DAY_NUM_W-1:0] start_num, end_num;
   logic start_ok, end_ok;

   assign req = req_chan.payload;

   always_comb begin
      load[NS] = !v_ff[NS] || rsp_chan.ready;
      for (int k = NS - 1; k >= 0; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
      stage_ctl.load = load[NS-1:0];
   end

   assign req_chan.ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (load[0]) begin
            v_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k <= NS; k++) begin
            if (load[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         gt_ff[0] <= req.start_year > req.end_year;
      end
      for (int k = 1; k < NS; k++) begin
         if (load[k]) begin
            gt_ff[k] <= gt_ff[k-1];
         end
      end
   end

   gdd_day_number #(.MAX_YEAR(MAX_YEAR)) u_start (
      .clock     (clock),
      .stage_ctl (stage_ctl),
      .day       (req.start_day),
      .month     (req.start_month),
      .year      (req.start_year),
      .day_num   (start_num),
      .date_ok   (start_ok)
   );

   gdd_day_number #(.MAX_YEAR(MAX_YEAR)) u_end (
      .clock     (clock),
      .stage_ctl (stage_ctl),
      .day       (req.end_day),
      .month     (req.end_month),
      .year      (req.end_year),
      .day_num   (end_num),
      .date_ok   (end_ok)
   );

   always_comb begin
      rsp_in.status    = !(start_ok && end_ok) || gt_ff[NS-1];
      rsp_in.day_count = rsp_in.status ? '0 : $signed(end_num - start_num);
   end

   always_ff @(posedge clock) begin
      if (load[NS]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = v_ff[NS];
   assign rsp_chan.payload = rsp_ff;

endmodule
